// ----- rtl/core/tmprof_pkg.sv -----
`timescale 1ns / 1ps

package tmprof_pkg;

   localparam int TICK_W = 32;
   localparam int DATA_W = 32;
   // Doubled position is formed exactly at this width.
   localparam int POS_W  = 104;

   typedef enum logic [2:0] {
      PHASE_HOLD_START = 3'd0,
      PHASE_ACCEL      = 3'd1,
      PHASE_CRUISE     = 3'd2,
      PHASE_DECEL      = 3'd3,
      PHASE_DONE       = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      CSR_ACCEL_START = 3'd0,
      CSR_ACCEL_END   = 3'd1,
      CSR_DECEL_START = 3'd2,
      CSR_MOVE_END    = 3'd3,
      CSR_START_POS   = 3'd4,
      CSR_FINAL_POS   = 3'd5,
      CSR_ACCEL_RATE  = 3'd6,
      CSR_DECEL_RATE  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              clipped;
   } clamp_type;

   function automatic clamp_type clamp32(input logic signed [POS_W-1:0] x);
      clamp_type r;
      if (&x[POS_W-1:DATA_W-1] || ~|x[POS_W-1:DATA_W-1]) begin
         r.value   = x[DATA_W-1:0];
         r.clipped = 1'b0;
      end else begin
         r.value   = x[POS_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
         r.clipped = 1'b1;
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/trapezoid_motion_profile_core.sv -----
`timescale 1ns / 1ps

// Trapezoidal motion profile generator, single axis.
// Input: pulse start with req_tick_index; a transaction is taken at every
// clock edge with start high and busy low. busy stays low, so a new tick
// may be issued in every cycle.
// Output: rsp_valid strobes for one cycle with desired velocity, desired
// position (Q16.16, saturated), phase code and the saturation flag.
// Pipeline: six register stages (phase select, first products, second
// products, partial sums, final sum, output clamp). Throughput: one
// transaction per cycle.
// The receiver cannot stall; results are shown exactly once, in order.
// Configuration: csr_write_enable writes csr_write_data to register
// csr_index in the same edge. Write only while no transaction is in flight.
// Reset (synchronous, active high) clears all profile registers to zero
// and drops every transaction in flight.
module trapezoid_motion_profile_core
   import tmprof_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [TICK_W-1:0]        req_tick_index,
   input  logic                     csr_write_enable,
   input  logic [2:0]               csr_index,
   input  logic [DATA_W-1:0]        csr_write_data,
   output logic                     rsp_valid,
   output logic signed [DATA_W-1:0] rsp_desired_velocity,
   output logic signed [DATA_W-1:0] rsp_desired_position,
   output logic [2:0]               rsp_phase_code,
   output logic                     rsp_saturated
);

   logic [TICK_W-1:0]        accel_start_ff, accel_end_ff, decel_start_ff, move_end_ff;
   logic signed [DATA_W-1:0] start_pos_ff, final_pos_ff, accel_rate_ff, decel_rate_ff;

   logic accept;
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // stage 1: phase and time offsets
   logic              s1_valid_ff;
   phase_type         s1_phase_ff, s1_phase_in;
   logic [TICK_W-1:0] s1_t_ff, s1_t_in, base;
   logic signed [TICK_W:0] s1_ta_ff, s1_ta_in, s1_tc_ff, s1_tc_in;

   always_comb begin
      if (req_tick_index <= accel_start_ff) begin
         s1_phase_in = PHASE_HOLD_START;
      end else if (req_tick_index <= accel_end_ff) begin
         s1_phase_in = PHASE_ACCEL;
      end else if (req_tick_index <= decel_start_ff) begin
         s1_phase_in = PHASE_CRUISE;
      end else if (req_tick_index <= move_end_ff) begin
         s1_phase_in = PHASE_DECEL;
      end else begin
         s1_phase_in = PHASE_DONE;
      end
      case (s1_phase_in)
         PHASE_ACCEL:  base = accel_start_ff;
         PHASE_CRUISE: base = accel_end_ff;
         default:      base = decel_start_ff;
      endcase
      s1_t_in  = req_tick_index - base;
      s1_ta_in = $signed({1'b0, accel_end_ff}) - $signed({1'b0, accel_start_ff});
      s1_tc_in = $signed({1'b0, decel_start_ff}) - $signed({1'b0, accel_end_ff});
   end

   // stage 2: acc*t or acc*Ta, dec*t, t*t, and the multiplier for stage 3
   logic                   s2_valid_ff;
   phase_type              s2_phase_ff;
   logic signed [64:0]     s2_p_ff, s2_p_in, s2_dt_ff, s2_dt_in;
   logic [63:0]            s2_tt_ff, s2_tt_in;
   logic signed [34:0]     s2_x_ff, s2_x_in;
   logic signed [TICK_W:0] m_sel, t_s;

   always_comb begin
      t_s      = $signed({1'b0, s1_t_ff});
      m_sel    = (s1_phase_ff == PHASE_ACCEL) ? t_s : s1_ta_ff;
      s2_p_in  = 65'(accel_rate_ff * m_sel);
      s2_dt_in = 65'(decel_rate_ff * t_s);
      s2_tt_in = 64'(s1_t_ff * s1_t_ff);
      if (s1_phase_ff == PHASE_ACCEL) begin
         s2_x_in = $signed({3'b000, s1_t_ff});
      end else begin
         s2_x_in = 35'(s1_ta_ff) + $signed({2'b00, s1_t_ff, 1'b0});
         if (s1_phase_ff == PHASE_DECEL) begin
            s2_x_in = s2_x_in + $signed({s1_tc_ff, 1'b0});
         end
      end
   end

   // stage 3: velocity and the four wide partial products
   logic               s3_valid_ff;
   phase_type          s3_phase_ff;
   logic signed [65:0] s3_vel_ff, s3_vel_in;
   logic signed [67:0] s3_pxl_ff, s3_pxl_in, s3_pxh_ff, s3_pxh_in;
   logic signed [64:0] s3_dl_ff, s3_dl_in, s3_dh_ff, s3_dh_in;
   logic signed [32:0] p_lo, p_hi, tt_lo, tt_hi;

   always_comb begin
      p_lo      = $signed({1'b0, s2_p_ff[31:0]});
      p_hi      = s2_p_ff[64:32];
      tt_lo     = $signed({1'b0, s2_tt_ff[31:0]});
      tt_hi     = $signed({1'b0, s2_tt_ff[63:32]});
      s3_vel_in = (s2_phase_ff == PHASE_DECEL) ? 66'(s2_p_ff) - 66'(s2_dt_ff) : 66'(s2_p_ff);
      s3_pxl_in = 68'(p_lo * s2_x_ff);
      s3_pxh_in = 68'(p_hi * s2_x_ff);
      s3_dl_in  = 65'(decel_rate_ff * tt_lo);
      s3_dh_in  = 65'(decel_rate_ff * tt_hi);
   end

   // stage 4: recombine partial products
   logic                    s4_valid_ff;
   phase_type               s4_phase_ff;
   logic signed [65:0]      s4_vel_ff;
   logic signed [POS_W-1:0] s4_px_ff, s4_px_in, s4_dd_ff, s4_dd_in;

   assign s4_px_in = (POS_W'(s3_pxh_ff) <<< 32) + POS_W'(s3_pxl_ff);
   assign s4_dd_in = (POS_W'(s3_dh_ff) <<< 32) + POS_W'(s3_dl_ff);

   // stage 5: doubled position, velocity clamp
   logic                    s5_valid_ff;
   phase_type               s5_phase_ff;
   logic signed [POS_W-1:0] s5_pos2_ff, s5_pos2_in;
   clamp_type               s5_vel_ff, s5_vel_in;

   always_comb begin
      s5_pos2_in = s4_px_ff + (POS_W'(start_pos_ff) <<< 1);
      if (s4_phase_ff == PHASE_DECEL) begin
         s5_pos2_in = s5_pos2_in - s4_dd_ff;
      end
      s5_vel_in = clamp32(POS_W'(s4_vel_ff));
   end

   // output stage
   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] vel_out_ff, vel_out_in, pos_out_ff, pos_out_in;
   logic [2:0]               phase_out_ff;
   logic                     sat_out_ff, sat_out_in;
   clamp_type                pos_c;

   always_comb begin
      pos_c = clamp32(s5_pos2_ff >>> 1);
      unique case (s5_phase_ff)
         PHASE_HOLD_START: begin
            vel_out_in = '0;
            pos_out_in = start_pos_ff;
            sat_out_in = 1'b0;
         end
         PHASE_DONE: begin
            vel_out_in = '0;
            pos_out_in = final_pos_ff;
            sat_out_in = 1'b0;
         end
         default: begin
            vel_out_in = s5_vel_ff.value;
            pos_out_in = pos_c.value;
            sat_out_in = s5_vel_ff.clipped | pos_c.clipped;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_start_ff <= '0;
         accel_end_ff   <= '0;
         decel_start_ff <= '0;
         move_end_ff    <= '0;
         start_pos_ff   <= '0;
         final_pos_ff   <= '0;
         accel_rate_ff  <= '0;
         decel_rate_ff  <= '0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         s3_valid_ff    <= 1'b0;
         s4_valid_ff    <= 1'b0;
         s5_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index_type'(csr_index))
               CSR_ACCEL_START: accel_start_ff <= csr_write_data;
               CSR_ACCEL_END:   accel_end_ff   <= csr_write_data;
               CSR_DECEL_START: decel_start_ff <= csr_write_data;
               CSR_MOVE_END:    move_end_ff    <= csr_write_data;
               CSR_START_POS:   start_pos_ff   <= csr_write_data;
               CSR_FINAL_POS:   final_pos_ff   <= csr_write_data;
               CSR_ACCEL_RATE:  accel_rate_ff  <= csr_write_data;
               CSR_DECEL_RATE:  decel_rate_ff  <= csr_write_data;
            endcase
         end
         s1_valid_ff  <= accept;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         rsp_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_phase_ff  <= s1_phase_in;
      s1_t_ff      <= s1_t_in;
      s1_ta_ff     <= s1_ta_in;
      s1_tc_ff     <= s1_tc_in;
      s2_phase_ff  <= s1_phase_ff;
      s2_p_ff      <= s2_p_in;
      s2_dt_ff     <= s2_dt_in;
      s2_tt_ff     <= s2_tt_in;
      s2_x_ff      <= s2_x_in;
      s3_phase_ff  <= s2_phase_ff;
      s3_vel_ff    <= s3_vel_in;
      s3_pxl_ff    <= s3_pxl_in;
      s3_pxh_ff    <= s3_pxh_in;
      s3_dl_ff     <= s3_dl_in;
      s3_dh_ff     <= s3_dh_in;
      s4_phase_ff  <= s3_phase_ff;
      s4_vel_ff    <= s3_vel_ff;
      s4_px_ff     <= s4_px_in;
      s4_dd_ff     <= s4_dd_in;
      s5_phase_ff  <= s4_phase_ff;
      s5_pos2_ff   <= s5_pos2_in;
      s5_vel_ff    <= s5_vel_in;
      vel_out_ff   <= vel_out_in;
      pos_out_ff   <= pos_out_in;
      phase_out_ff <= s5_phase_ff;
      sat_out_ff   <= sat_out_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_desired_velocity = vel_out_ff;
   assign rsp_desired_position = pos_out_ff;
   assign rsp_phase_code       = phase_out_ff;
   assign rsp_saturated        = sat_out_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##6 rsp_valid)
      else $error("transaction result missing after six cycles");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 6))
      else $error("result strobe without a matching transaction");

   a_hold_no_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_phase_code == PHASE_HOLD_START || rsp_phase_code == PHASE_DONE)
      |-> !rsp_saturated && rsp_desired_velocity == '0)
      else $error("hold phase with motion or saturation");

   a_stage_phase: assert property (@(posedge clock) disable iff (reset)
      s5_valid_ff |=> rsp_phase_code == $past(s5_phase_ff))
      else $error("phase code lost between pipeline stages");

endmodule
